FILE: rtl/sbt_pkg.sv
package sbt_pkg;

    localparam int KEYWORD_CHARS = 8;
    localparam int LENGTH_BITS   = 16;
    localparam int LINE_BITS     = 24;
    localparam int VALUE_BITS    = 31;
    localparam int MAX_RESULTS   = 3;
    localparam int KW_COUNT      = 15;
    localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0]  VAL_MAX   = {VALUE_BITS{1'b1}};

    // Token kinds
    localparam logic [5:0] KIND_IDENT   = 6'd0;
    localparam logic [5:0] KIND_INT     = 6'd1;
    localparam logic [5:0] KIND_CHAR    = 6'd2;
    localparam logic [5:0] KIND_STRING  = 6'd3;
    localparam logic [5:0] KIND_KW_BASE = 6'd4;
    localparam logic [5:0] KIND_PLUS    = 6'd19;
    localparam logic [5:0] KIND_MINUS   = 6'd20;
    localparam logic [5:0] KIND_MUL     = 6'd21;
    localparam logic [5:0] KIND_DIV     = 6'd22;
    localparam logic [5:0] KIND_LT      = 6'd23;
    localparam logic [5:0] KIND_LE      = 6'd24;
    localparam logic [5:0] KIND_GT      = 6'd25;
    localparam logic [5:0] KIND_GE      = 6'd26;
    localparam logic [5:0] KIND_EQEQ    = 6'd27;
    localparam logic [5:0] KIND_NE      = 6'd28;
    localparam logic [5:0] KIND_COLON   = 6'd29;
    localparam logic [5:0] KIND_ASSIGN  = 6'd30;
    localparam logic [5:0] KIND_SEMI    = 6'd31;
    localparam logic [5:0] KIND_COMMA   = 6'd32;
    localparam logic [5:0] KIND_LPAREN  = 6'd33;
    localparam logic [5:0] KIND_RPAREN  = 6'd34;
    localparam logic [5:0] KIND_LBRACK  = 6'd35;
    localparam logic [5:0] KIND_RBRACK  = 6'd36;
    localparam logic [5:0] KIND_LBRACE  = 6'd37;
    localparam logic [5:0] KIND_RBRACE  = 6'd38;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EMPTY_CHAR = 3'd1;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd2;
    localparam logic [2:0] ERR_OPEN_CHAR  = 3'd3;
    localparam logic [2:0] ERR_EMPTY_STR  = 3'd4;
    localparam logic [2:0] ERR_BAD_STR    = 3'd5;
    localparam logic [2:0] ERR_LONE_BANG  = 3'd6;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd7;

    // Byte codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TILDE  = 8'd126;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_QUOTE  = 8'd39;
    localparam logic [7:0] CH_UNDER  = 8'd95;

    typedef enum logic [3:0] {
        ST_IDLE, ST_IDENT, ST_NUM, ST_CH_OPEN, ST_CH_BODY, ST_CH_SKIP,
        ST_STR_OPEN, ST_STR_BODY, ST_LT, ST_GT, ST_EQ, ST_BANG
    } scan_state_t;

    typedef logic [KEYWORD_CHARS-1:0][7:0] kw_buf_t;

    typedef struct packed {
        logic [5:0]            kind;
        logic [2:0]            err;
        logic [LENGTH_BITS-1:0] len;
        logic [VALUE_BITS-1:0] val;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [LINE_BITS-1:0]   line;
        logic [1:0]             cnt;
    } bundle_t;

    function automatic res_t mk_res(logic [5:0] kind, logic [2:0] err,
                                    logic [LENGTH_BITS-1:0] len,
                                    logic [VALUE_BITS-1:0] val);
        res_t r;
        r.kind = kind;
        r.err  = err;
        r.len  = len;
        r.val  = val;
        return r;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_word(logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CH_UNDER;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    endfunction

    // Kind of a one-byte token that is emitted at once; identifier code if none
    function automatic logic [5:0] single_kind(logic [7:0] b);
        logic [5:0] k;
        k = KIND_IDENT;
        case (b)
            8'h2b: k = KIND_PLUS;
            8'h2d: k = KIND_MINUS;
            8'h2a: k = KIND_MUL;
            8'h2f: k = KIND_DIV;
            8'h3a: k = KIND_COLON;
            8'h3b: k = KIND_SEMI;
            8'h2c: k = KIND_COMMA;
            8'h28: k = KIND_LPAREN;
            8'h29: k = KIND_RPAREN;
            8'h5b: k = KIND_LBRACK;
            8'h5d: k = KIND_RBRACK;
            8'h7b: k = KIND_LBRACE;
            8'h7d: k = KIND_RBRACE;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic scan_state_t start_state(logic [7:0] b);
        scan_state_t s;
        s = ST_IDLE;
        if (is_alpha(b) || b == CH_UNDER) s = ST_IDENT;
        else if (is_digit(b))             s = ST_NUM;
        else if (b == CH_QUOTE)           s = ST_CH_OPEN;
        else if (b == CH_DQUOTE)          s = ST_STR_OPEN;
        else if (b == 8'h3c)              s = ST_LT;
        else if (b == 8'h3e)              s = ST_GT;
        else if (b == 8'h3d)              s = ST_EQ;
        else if (b == 8'h21)              s = ST_BANG;
        return s;
    endfunction

    function automatic logic [63:0] kw_word(int i);
        logic [63:0] w;
        case (i)
            0:  w = "const";
            1:  w = "int";
            2:  w = "char";
            3:  w = "void";
            4:  w = "main";
            5:  w = "if";
            6:  w = "else";
            7:  w = "switch";
            8:  w = "case";
            9:  w = "default";
            10: w = "while";
            11: w = "for";
            12: w = "scanf";
            13: w = "printf";
            default: w = "return";
        endcase
        return w;
    endfunction

    function automatic int kw_len(int i);
        int l;
        case (i)
            0, 10, 12:     l = 5;
            1, 11:         l = 3;
            5:             l = 2;
            7, 13, 14:     l = 6;
            9:             l = 7;
            default:       l = 4;
        endcase
        return l;
    endfunction

    // Parallel compare of the lowercased buffer against every reserved word
    function automatic logic [5:0] kw_kind(kw_buf_t bufv, logic [LENGTH_BITS-1:0] len);
        logic [5:0]  k;
        logic        hit;
        logic [7:0]  ch;
        logic [63:0] w;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            w   = kw_word(i);
            hit = (len == LENGTH_BITS'(kw_len(i)));
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if (j < kw_len(i)) ch = w[(kw_len(i) - 1 - j) * 8 +: 8];
                else               ch = 8'h00;
                if (bufv[j] != ch) hit = 1'b0;
            end
            if (hit && k == KIND_IDENT) k = 6'(KIND_KW_BASE + 6'(i));
        end
        return k;
    endfunction

endpackage

FILE: rtl/sbt_if.sv
interface sbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sbt_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] token_length;
    logic [30:0] token_value;
    logic [23:0] line_number;
    logic        last_result;

    modport source (output valid, output token_kind, output error_code, output token_length,
                    output token_value, output line_number, output last_result,
                    input ready);
    modport sink   (input valid, input token_kind, input error_code, input token_length,
                    input token_value, input line_number, input last_result,
                    output ready);
endinterface

FILE: rtl/source_byte_tokenizer.sv
// Byte-serial lexical scanner. One byte (or an end-of-input mark) is taken
// per cycle while the internal two-entry result queue has room; each byte
// yields zero to three result words, which leave one per cycle while the
// output is ready, with last_result set on the final word of that byte. A
// byte that yields at most one result sustains one byte per cycle if the
// output never stalls; one that yields more holds the output for each of
// its words, so the output port sets the long-run rate. Results pass through
// the queue registers. There is no clearing pass after reset.
module source_byte_tokenizer (
    input  logic      clk,
    input  logic      rst_n,
    sbt_in_if.sink    in_ch,
    sbt_out_if.source out_ch
);
    import sbt_pkg::*;

    logic    q_full;
    logic    push;
    bundle_t push_data;
    logic    pop;
    bundle_t head;
    logic    head_valid;

    sbt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    sbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    sbt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

FILE: rtl/sbt_front.sv
module sbt_front (
    input  logic             clk,
    input  logic             rst_n,
    sbt_in_if.sink           in_ch,
    input  logic             q_full,
    output logic             push,
    output sbt_pkg::bundle_t push_data
);
    import sbt_pkg::*;

    scan_state_t            state_reg, state_next;
    kw_buf_t                kw_reg, kw_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic                   cerr_reg, cerr_next;
    res_t [MAX_RESULTS-1:0] res_v;
    logic [1:0]             n_v;
    logic                   fire;
    logic [7:0]             b;
    logic                   eof;

    assign in_ch.ready = !q_full;
    assign fire        = in_ch.valid && in_ch.ready;
    assign b           = in_ch.in_byte;
    assign eof         = in_ch.end_of_input;

    // Next scan state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!eof) state_next = start_state(b);
            ST_IDENT:
                if (eof)               state_next = ST_IDLE;
                else if (!is_word(b))  state_next = start_state(b);
            ST_NUM:
                if (eof)               state_next = ST_IDLE;
                else if (!is_digit(b)) state_next = start_state(b);
            ST_CH_OPEN:
                state_next = (eof || b == CH_QUOTE) ? ST_IDLE : ST_CH_BODY;
            ST_CH_BODY:
                state_next = (eof || b == CH_QUOTE) ? ST_IDLE : ST_CH_SKIP;
            ST_CH_SKIP:
                if (eof || b == CH_QUOTE) state_next = ST_IDLE;
            ST_STR_OPEN:
                state_next = (eof || b == CH_DQUOTE) ? ST_IDLE : ST_STR_BODY;
            ST_STR_BODY:
                if (eof || b == CH_DQUOTE) state_next = ST_IDLE;
            ST_LT, ST_GT, ST_EQ:
                if (eof || b == 8'h3d) state_next = ST_IDLE;
                else                   state_next = start_state(b);
            ST_BANG:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Results and datapath for the current byte
    always_comb
    begin : data_comb
        logic        do_start;
        logic [34:0] acc;
        logic [5:0]  sk;
        logic        legal;
        do_start  = 1'b0;
        n_v       = 2'd0;
        res_v     = '0;
        kw_next   = kw_reg;
        len_next  = len_reg;
        val_next  = val_reg;
        line_next = line_reg;
        cerr_next = cerr_reg;
        acc       = '0;
        sk        = KIND_IDENT;
        legal     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
                do_start = !eof;
            ST_IDENT:
                if (!eof && is_word(b))
                begin
                    if (len_reg < LENGTH_BITS'(KEYWORD_CHARS))
                        kw_next[len_reg[KW_IDX_W-1:0]] = to_lower(b);
                    if (len_reg != LEN_MAX) len_next = len_reg + 1'b1;
                end
                else
                begin
                    res_v[n_v] = mk_res(kw_kind(kw_reg, len_reg), ERR_NONE, len_reg, '0);
                    n_v        = n_v + 2'd1;
                    do_start   = !eof;
                end
            ST_NUM:
                if (!eof && is_digit(b))
                begin
                    acc = ({4'b0, val_reg} << 3) + ({4'b0, val_reg} << 1)
                        + {31'b0, b[3:0]};
                    val_next = (acc > {4'b0, VAL_MAX}) ? VAL_MAX : acc[VALUE_BITS-1:0];
                    if (len_reg != LEN_MAX) len_next = len_reg + 1'b1;
                end
                else
                begin
                    res_v[n_v] = mk_res(KIND_INT, ERR_NONE, len_reg, val_reg);
                    n_v        = n_v + 2'd1;
                    do_start   = !eof;
                end
            ST_CH_OPEN:
                if (eof || b == CH_QUOTE)
                begin
                    res_v[n_v] = mk_res(KIND_IDENT, eof ? ERR_OPEN_CHAR : ERR_EMPTY_CHAR,
                                        '0, '0);
                    n_v        = n_v + 2'd1;
                    res_v[n_v] = mk_res(KIND_CHAR, ERR_NONE, '0, '0);
                    n_v        = n_v + 2'd1;
                end
                else
                begin
                    legal = is_word(b) || single_kind(b) == KIND_PLUS
                         || single_kind(b) == KIND_MINUS || single_kind(b) == KIND_MUL
                         || single_kind(b) == KIND_DIV;
                    cerr_next = !legal;
                    val_next  = {23'b0, b};
                    len_next  = LENGTH_BITS'(1);
                end
            ST_CH_BODY:
            begin
                if (cerr_reg)
                begin
                    res_v[n_v] = mk_res(KIND_IDENT, ERR_BAD_CHAR, '0, '0);
                    n_v        = n_v + 2'd1;
                    cerr_next  = 1'b0;
                end
                if (!eof && b == CH_QUOTE)
                begin
                    res_v[n_v] = mk_res(KIND_CHAR, ERR_NONE, LENGTH_BITS'(1), val_reg);
                    n_v        = n_v + 2'd1;
                end
                else
                begin
                    res_v[n_v] = mk_res(KIND_IDENT, ERR_OPEN_CHAR, '0, '0);
                    n_v        = n_v + 2'd1;
                    if (eof)
                    begin
                        res_v[n_v] = mk_res(KIND_CHAR, ERR_NONE, LENGTH_BITS'(1), val_reg);
                        n_v        = n_v + 2'd1;
                    end
                end
            end
            ST_CH_SKIP:
                if (eof || b == CH_QUOTE)
                begin
                    res_v[n_v] = mk_res(KIND_CHAR, ERR_NONE, LENGTH_BITS'(1), val_reg);
                    n_v        = n_v + 2'd1;
                end
            ST_STR_OPEN:
                if (eof || b == CH_DQUOTE)
                begin
                    res_v[n_v] = mk_res(KIND_IDENT, ERR_EMPTY_STR, '0, '0);
                    n_v        = n_v + 2'd1;
                    res_v[n_v] = mk_res(KIND_STRING, ERR_NONE, '0, '0);
                    n_v        = n_v + 2'd1;
                end
                else
                begin
                    if (b < CH_SPACE || b > CH_TILDE)
                    begin
                        res_v[n_v] = mk_res(KIND_IDENT, ERR_BAD_STR, '0, '0);
                        n_v        = n_v + 2'd1;
                    end
                    len_next = LENGTH_BITS'(1);
                end
            ST_STR_BODY:
                if (eof || b == CH_DQUOTE)
                begin
                    res_v[n_v] = mk_res(KIND_STRING, ERR_NONE, len_reg, '0);
                    n_v        = n_v + 2'd1;
                end
                else
                begin
                    if (b < CH_SPACE || b > CH_TILDE)
                    begin
                        res_v[n_v] = mk_res(KIND_IDENT, ERR_BAD_STR, '0, '0);
                        n_v        = n_v + 2'd1;
                    end
                    if (len_reg != LEN_MAX) len_next = len_reg + 1'b1;
                end
            ST_LT, ST_GT, ST_EQ:
                if (!eof && b == 8'h3d)
                begin
                    res_v[n_v] = mk_res((state_reg == ST_LT) ? KIND_LE :
                                        (state_reg == ST_GT) ? KIND_GE : KIND_EQEQ,
                                        ERR_NONE, LENGTH_BITS'(2), '0);
                    n_v        = n_v + 2'd1;
                end
                else
                begin
                    res_v[n_v] = mk_res((state_reg == ST_LT) ? KIND_LT :
                                        (state_reg == ST_GT) ? KIND_GT : KIND_ASSIGN,
                                        ERR_NONE, LENGTH_BITS'(1), '0);
                    n_v        = n_v + 2'd1;
                    do_start   = !eof;
                end
            ST_BANG:
            begin
                if (!eof && b == 8'h3d)
                    res_v[n_v] = mk_res(KIND_NE, ERR_NONE, LENGTH_BITS'(2), '0);
                else
                    res_v[n_v] = mk_res(KIND_IDENT, ERR_LONE_BANG, '0, '0);
                n_v = n_v + 2'd1;
            end
            default:
                do_start = 1'b0;
        endcase

        // Classify a byte met between tokens
        if (do_start)
        begin
            sk = single_kind(b);
            if (is_space(b))
            begin
                if (b == CH_NL && line_reg != LINE_MAX) line_next = line_reg + 1'b1;
            end
            else if (is_alpha(b) || b == CH_UNDER)
            begin
                kw_next    = '0;
                kw_next[0] = to_lower(b);
                len_next   = LENGTH_BITS'(1);
            end
            else if (is_digit(b))
            begin
                len_next = LENGTH_BITS'(1);
                val_next = {27'b0, b[3:0]};
            end
            else if (b == CH_QUOTE)
            begin
                len_next  = '0;
                val_next  = '0;
                cerr_next = 1'b0;
            end
            else if (b == CH_DQUOTE)
            begin
                len_next = '0;
                val_next = '0;
            end
            else if (start_state(b) == ST_IDLE)
            begin
                if (sk != KIND_IDENT)
                    res_v[n_v] = mk_res(sk, ERR_NONE, LENGTH_BITS'(1), '0);
                else
                    res_v[n_v] = mk_res(KIND_IDENT, ERR_UNKNOWN, '0, '0);
                n_v = n_v + 2'd1;
            end
        end
    end

    // Hand finished results to the queue
    assign push           = fire && (n_v != 2'd0);
    assign push_data.res  = res_v;
    assign push_data.line = line_reg;
    assign push_data.cnt  = n_v;

    // Advance scan state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kw_reg    <= '0;
            len_reg   <= '0;
            val_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            cerr_reg  <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            kw_reg    <= kw_next;
            len_reg   <= len_next;
            val_reg   <= val_next;
            line_reg  <= line_next;
            cerr_reg  <= cerr_next;
        end
    end

endmodule

FILE: rtl/sbt_queue.sv
module sbt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sbt_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output sbt_pkg::bundle_t head,
    output logic             head_valid
);
    import sbt_pkg::*;

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = mem_reg[rd_ptr_reg];

    // Store a pushed bundle
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Track pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

FILE: rtl/sbt_back.sv
module sbt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sbt_pkg::bundle_t head,
    input  logic             head_valid,
    output logic             pop,
    sbt_out_if.source        out_ch
);
    import sbt_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       fire;
    res_t       cur;

    assign cur  = head.res[idx_reg];
    assign last = idx_reg == (head.cnt - 2'd1);
    assign fire = out_ch.valid && out_ch.ready;
    assign pop  = fire && last;

    assign out_ch.valid        = head_valid;
    assign out_ch.token_kind   = cur.kind;
    assign out_ch.error_code   = cur.err;
    assign out_ch.token_length = cur.len;
    assign out_ch.token_value  = cur.val;
    assign out_ch.line_number  = head.line;
    assign out_ch.last_result  = last;

    // Step through the results of the head bundle
    always_comb
    begin
        idx_next = idx_reg;
        if (fire) idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) idx_reg <= 2'd0;
        else        idx_reg <= idx_next;
    end

endmodule

FILE: rtl/sbt_check.sv
module sbt_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [2:0]  error_code,
    input logic [15:0] token_length,
    input logic [30:0] token_value,
    input logic [23:0] line_number
);
    import sbt_pkg::*;

    logic [23:0] last_line_reg;

    // Hold the line of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                     last_line_reg <= 24'd1;
        else if (out_valid && out_ready) last_line_reg <= line_number;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |->
            token_kind == KIND_IDENT && token_length == 16'd0 && token_value == 31'd0)
        else $error("error word carries token fields");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_number != 24'd0)
        else $error("line number zero");

    a_line_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> line_number >= last_line_reg)
        else $error("line number went backwards");

endmodule

bind source_byte_tokenizer sbt_check u_sbt_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .token_kind   (out_ch.token_kind),
    .error_code   (out_ch.error_code),
    .token_length (out_ch.token_length),
    .token_value  (out_ch.token_value),
    .line_number  (out_ch.line_number)
);

FILE: tb/sbt_scoreboard.sv
`timescale 1ns / 100ps

package sbt_tb_pkg;
    import sbt_pkg::*;

    typedef struct {
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [15:0] len;
        logic [30:0] val;
        logic [23:0] line;
        logic        last;
    } token_word_t;

    class token_scoreboard;
        scan_state_t       state;
        logic [7:0]        kw_buf [KEYWORD_CHARS];
        logic [15:0]       len_cnt;
        logic [30:0]       val_acc;
        logic [23:0]       line_cnt;
        logic              bad_char;
        token_word_t       pending_tokens [$];
        token_word_t       step_words [$];
        int                mismatches;

        function new();
            state = ST_IDLE;
            foreach (kw_buf[i]) kw_buf[i] = 8'h00;
            len_cnt = '0;
            val_acc = '0;
            line_cnt = 24'd1;
            bad_char = 1'b0;
            mismatches = 0;
        endfunction

        function void push(logic [5:0] k, logic [2:0] e, logic [15:0] l, logic [30:0] v);
            token_word_t w;
            w.kind = k;
            w.err = e;
            w.len = l;
            w.val = v;
            w.line = line_cnt;
            w.last = 1'b0;
            step_words.push_back(w);
        endfunction

        function logic is_al(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function logic is_dg(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function logic is_wd(logic [7:0] b);
            return is_al(b) || is_dg(b) || b == "_";
        endfunction

        function logic [7:0] lower(logic [7:0] b);
            return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        endfunction

        // Match the lowercased buffer against the reserved word list
        function logic [5:0] word_kind();
            string names [15] = '{"const", "int", "char", "void", "main", "if", "else",
                "switch", "case", "default", "while", "for", "scanf", "printf", "return"};
            logic hit;
            for (int i = 0; i < 15; i++) begin
                hit = (len_cnt == 16'(names[i].len()));
                for (int j = 0; j < KEYWORD_CHARS; j++)
                    if (kw_buf[j] != ((j < names[i].len()) ? names[i][j] : 8'h00))
                        hit = 1'b0;
                if (hit) return 6'(KIND_KW_BASE + i);
            end
            return KIND_IDENT;
        endfunction

        function void begin_token(logic [7:0] b);
            logic [5:0] sk;
            state = ST_IDLE;
            if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) begin
                if (b == CH_NL && line_cnt != LINE_MAX) line_cnt++;
            end else if (is_al(b) || b == CH_UNDER) begin
                foreach (kw_buf[i]) kw_buf[i] = 8'h00;
                kw_buf[0] = lower(b);
                len_cnt = 16'd1;
                state = ST_IDENT;
            end else if (is_dg(b)) begin
                len_cnt = 16'd1;
                val_acc = 31'(b - "0");
                state = ST_NUM;
            end else if (b == CH_QUOTE) begin
                len_cnt = '0;
                val_acc = '0;
                bad_char = 1'b0;
                state = ST_CH_OPEN;
            end else if (b == CH_DQUOTE) begin
                len_cnt = '0;
                val_acc = '0;
                state = ST_STR_OPEN;
            end else if (b == "<") state = ST_LT;
            else if (b == ">") state = ST_GT;
            else if (b == "=") state = ST_EQ;
            else if (b == "!") state = ST_BANG;
            else begin
                case (b)
                    "+": sk = KIND_PLUS;   "-": sk = KIND_MINUS;
                    "*": sk = KIND_MUL;    "/": sk = KIND_DIV;
                    ":": sk = KIND_COLON;  ";": sk = KIND_SEMI;
                    ",": sk = KIND_COMMA;  "(": sk = KIND_LPAREN;
                    ")": sk = KIND_RPAREN; "[": sk = KIND_LBRACK;
                    "]": sk = KIND_RBRACK; "{": sk = KIND_LBRACE;
                    "}": sk = KIND_RBRACE;
                    default: sk = KIND_IDENT;
                endcase
                if (sk != KIND_IDENT) push(sk, ERR_NONE, 16'd1, '0);
                else push(KIND_IDENT, ERR_UNKNOWN, '0, '0);
            end
        endfunction

        // Note an accepted input word and queue the tokens it causes
        function void note_input(logic [7:0] b, logic eof);
            logic [63:0] v;
            logic [5:0]  k;
            step_words.delete();
            case (state)
                ST_IDENT:
                    if (!eof && is_wd(b)) begin
                        if (len_cnt < KEYWORD_CHARS) kw_buf[len_cnt] = lower(b);
                        if (len_cnt != LEN_MAX) len_cnt++;
                    end else begin
                        push(word_kind(), ERR_NONE, len_cnt, '0);
                        state = ST_IDLE;
                        if (!eof) begin_token(b);
                    end
                ST_NUM:
                    if (!eof && is_dg(b)) begin
                        v = 64'(val_acc) * 10 + 64'(b - "0");
                        val_acc = (v > 64'(VAL_MAX)) ? VAL_MAX : 31'(v);
                        if (len_cnt != LEN_MAX) len_cnt++;
                    end else begin
                        push(KIND_INT, ERR_NONE, len_cnt, val_acc);
                        state = ST_IDLE;
                        if (!eof) begin_token(b);
                    end
                ST_CH_OPEN:
                    if (eof || b == CH_QUOTE) begin
                        push(KIND_IDENT, eof ? ERR_OPEN_CHAR : ERR_EMPTY_CHAR, '0, '0);
                        push(KIND_CHAR, ERR_NONE, '0, '0);
                        state = ST_IDLE;
                    end else begin
                        bad_char = !(is_wd(b) || b == "+" || b == "-" || b == "*" || b == "/");
                        val_acc = 31'(b);
                        len_cnt = 16'd1;
                        state = ST_CH_BODY;
                    end
                ST_CH_BODY: begin
                    if (bad_char) begin
                        push(KIND_IDENT, ERR_BAD_CHAR, '0, '0);
                        bad_char = 1'b0;
                    end
                    if (!eof && b == CH_QUOTE) begin
                        push(KIND_CHAR, ERR_NONE, 16'd1, val_acc);
                        state = ST_IDLE;
                    end else begin
                        push(KIND_IDENT, ERR_OPEN_CHAR, '0, '0);
                        if (eof) begin
                            push(KIND_CHAR, ERR_NONE, 16'd1, val_acc);
                            state = ST_IDLE;
                        end else state = ST_CH_SKIP;
                    end
                end
                ST_CH_SKIP:
                    if (eof || b == CH_QUOTE) begin
                        push(KIND_CHAR, ERR_NONE, 16'd1, val_acc);
                        state = ST_IDLE;
                    end
                ST_STR_OPEN:
                    if (eof || b == CH_DQUOTE) begin
                        push(KIND_IDENT, ERR_EMPTY_STR, '0, '0);
                        push(KIND_STRING, ERR_NONE, '0, '0);
                        state = ST_IDLE;
                    end else begin
                        if (b < CH_SPACE || b > CH_TILDE) push(KIND_IDENT, ERR_BAD_STR, '0, '0);
                        len_cnt = 16'd1;
                        state = ST_STR_BODY;
                    end
                ST_STR_BODY:
                    if (eof || b == CH_DQUOTE) begin
                        push(KIND_STRING, ERR_NONE, len_cnt, '0);
                        state = ST_IDLE;
                    end else begin
                        if (b < CH_SPACE || b > CH_TILDE) push(KIND_IDENT, ERR_BAD_STR, '0, '0);
                        if (len_cnt != LEN_MAX) len_cnt++;
                    end
                ST_LT, ST_GT, ST_EQ: begin
                    k = (state == ST_LT) ? KIND_LT : (state == ST_GT) ? KIND_GT : KIND_EQEQ;
                    state = ST_IDLE;
                    if (!eof && b == "=") push((k == KIND_EQEQ) ? KIND_EQEQ : k + 6'd1,
                                               ERR_NONE, 16'd2, '0);
                    else begin
                        push((k == KIND_EQEQ) ? KIND_ASSIGN : k, ERR_NONE, 16'd1, '0);
                        if (!eof) begin_token(b);
                    end
                end
                ST_BANG: begin
                    if (!eof && b == "=") push(KIND_NE, ERR_NONE, 16'd2, '0);
                    else push(KIND_IDENT, ERR_LONE_BANG, '0, '0);
                    state = ST_IDLE;
                end
                default:
                    if (!eof) begin_token(b);
            endcase
            if (step_words.size() > 0) step_words[$].last = 1'b1;
            foreach (step_words[i]) pending_tokens.push_back(step_words[i]);
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endfunction

        // Compare one accepted output word with the oldest expectation
        function void check_output(token_word_t got);
            token_word_t w;
            if (pending_tokens.size() == 0) begin
                report($sformatf("unexpected word kind %0d err %0d", got.kind, got.err));
                return;
            end
            w = pending_tokens.pop_front();
            if (got.kind != w.kind) report($sformatf("kind %0d want %0d", got.kind, w.kind));
            if (got.err != w.err) report($sformatf("err %0d want %0d", got.err, w.err));
            if (got.len != w.len) report($sformatf("len %0d want %0d", got.len, w.len));
            if (got.val != w.val) report($sformatf("val %0d want %0d", got.val, w.val));
            if (got.line != w.line) report($sformatf("line %0d want %0d", got.line, w.line));
            if (got.last !== w.last) report($sformatf("last %b want %b", got.last, w.last));
        endfunction
    endclass
endpackage

FILE: tb/source_byte_tokenizer_test.sv
`timescale 1ns / 100ps

module source_byte_tokenizer_test;
    import sbt_pkg::*;
    import sbt_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   cycles;
    int   hold_off;
    logic long_hold;
    logic calm;

    sbt_in_if  in_ch ();
    sbt_out_if out_ch ();

    token_scoreboard sb;

    source_byte_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Send one byte, with a random gap first unless idling is off
    task automatic send_byte(logic [7:0] b, logic eof);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.end_of_input <= eof;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(b, eof);
    endtask

    // Drop valid after the last word of a batch
    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // Hand a fragment with random content, which may be a stray byte or end of input
    task automatic send_fragment();
        string words [8] = '{"int", "WHILE", "printf", "return", "Default", "x_1", "_a", "const"};
        string ops [10] = '{"<=", ">=", "==", "!=", "<", ">", "=", "{", "}", ";"};
        int n;
        case ($urandom_range(0, 7))
            0: send_text(words[$urandom_range(0, 7)]);
            1: begin
                n = $urandom_range(1, 12);
                repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            2: send_text(ops[$urandom_range(0, 9)]);
            3: begin
                send_byte(CH_QUOTE, 1'b0);
                send_byte(8'($urandom_range(33, 126)), 1'b0);
                send_byte(CH_QUOTE, 1'b0);
            end
            4: begin
                send_byte(CH_DQUOTE, 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) send_byte(8'($urandom_range(32, 126)), 1'b0);
                send_byte(CH_DQUOTE, 1'b0);
            end
            5: send_byte(8'($urandom_range(0, 255)), 1'b0);
            6: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            default: send_text(($urandom_range(0, 1)) ? " " : "\n");
        endcase
    endtask

    // Sink side: accept words with random stalls or a long hold-off
    always @(posedge clk) begin
        if (long_hold) begin
            long_hold <= 1'b0;
            hold_off <= 200;
            out_ch.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_off <= $urandom_range(1, 13);
            out_ch.ready <= 1'b0;
        end else
            out_ch.ready <= 1'b1;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            token_word_t w;
            w.kind = out_ch.token_kind;
            w.err = out_ch.error_code;
            w.len = out_ch.token_length;
            w.val = out_ch.token_value;
            w.line = out_ch.line_number;
            w.last = out_ch.last_result;
            sb.check_output(w);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        hold_off = 0;
        long_hold = 1'b0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.end_of_input = 1'b0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keywords, operators, char and string cases, errors
        send_text("PrintF returnx 2147483648 'a' '' '?' 'ab' \"\" \"a\x01\" !x\n");
        send_text("<= >= == != < > = + - * / : ; , ( ) [ ] { } @ ");
        send_byte(8'hff, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'h00, 1'b1);

        // Fill the block while the sink holds off
        long_hold = 1'b1;
        repeat (20) send_byte(";", 1'b0);
        stop_sending();

        // Pause until every expected word has come
        while (sb.pending_tokens.size() > 0) @(posedge clk);

        repeat (75) send_fragment();
        calm = 1'b1;
        repeat (20) send_fragment();
        send_byte(8'h00, 1'b1);
        stop_sending();

        while (sb.pending_tokens.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
